/* design/msr_pkg.sv */
// Shared constants, codes and item types of the motion sensor tracker.
`default_nettype none
package msr_pkg;

   localparam int EDGE_SLOTS = 5;
   localparam int SLOT_W = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(EDGE_SLOTS - 1);

   localparam logic [31:0] HOLD_TIME_RST    = 32'd5000;
   localparam logic [31:0] BURST_WINDOW_RST = 32'd20000;

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HOLD_TIME    = 2'd0,
      REG_BURST_WINDOW = 2'd1
   } reg_idx_type;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_HOLD  = 2'd1,
      CMD_PULSE = 2'd2,
      CMD_TAKE  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] now_ms;
      logic        raw_level;
      logic [31:0] arg_ms;
   } msr_req_type;

   typedef struct packed {
      logic        motion_level;
      logic        hold_active;
      logic [31:0] hold_left_ms;
      logic [31:0] current_high_ms;
      logic [31:0] total_high_ms;
      logic [7:0]  event_count;
      logic        unusual_now;
      logic        unusual_taken;
      logic        simulating;
   } msr_rsp_type;

   typedef struct packed {
      logic [31:0] hold_time_ms;
      logic [31:0] burst_window_ms;
   } msr_cfg_type;

endpackage
`default_nettype wire

/* design/msr_if.sv */
// Handshake channels of the motion sensor tracker: request, response and register write.
`default_nettype none
interface msr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] now_ms;
   logic        raw_level;
   logic [31:0] arg_ms;
   modport source (output valid, output cmd, output now_ms, output raw_level,
                   output arg_ms, input ready);
   modport sink (input valid, input cmd, input now_ms, input raw_level,
                 input arg_ms, output ready);
endinterface

interface msr_rsp_if;
   logic        valid;
   logic        ready;
   logic        motion_level;
   logic        hold_active;
   logic [31:0] hold_left_ms;
   logic [31:0] current_high_ms;
   logic [31:0] total_high_ms;
   logic [7:0]  event_count;
   logic        unusual_now;
   logic        unusual_taken;
   logic        simulating;
   modport source (output valid, output motion_level, output hold_active,
                   output hold_left_ms, output current_high_ms, output total_high_ms,
                   output event_count, output unusual_now, output unusual_taken,
                   output simulating, input ready);
   modport sink (input valid, input motion_level, input hold_active,
                 input hold_left_ms, input current_high_ms, input total_high_ms,
                 input event_count, input unusual_now, input unusual_taken,
                 input simulating, output ready);
endinterface

interface msr_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* design/msr_csr.sv */
// Configuration registers: hold time and burst window.
`default_nettype none
module msr_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   msr_csr_if.sink             csr_ch,
   output msr_pkg::msr_cfg_type cfg
);
   import msr_pkg::*;

   msr_cfg_type cfg_ff, cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (reg_idx_type'(csr_ch.index))
            REG_HOLD_TIME:    cfg_in.hold_time_ms    = csr_ch.data;
            REG_BURST_WINDOW: cfg_in.burst_window_ms = csr_ch.data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_time_ms    <= HOLD_TIME_RST;
         cfg_ff.burst_window_ms <= BURST_WINDOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* design/msr_burst.sv */
// Burst detector: parallel age compares of every edge stamp against the window.
`default_nettype none
module msr_burst (
   input  wire logic [31:0]                 now_ms,
   input  wire logic [31:0]                 window_ms,
   input  wire logic [31:0]                 stamps [msr_pkg::EDGE_SLOTS],
   input  wire logic                        wr_en,
   input  wire logic [msr_pkg::SLOT_W-1:0]  wr_slot,
   output logic                             all_recent
);
   import msr_pkg::*;

   logic [EDGE_SLOTS-1:0] recent;

   for (genvar i = 0; i < EDGE_SLOTS; i++) begin : g_slot
      // a slot written this step holds now_ms, so its age is zero
      assign recent[i] = (wr_en && (wr_slot == SLOT_W'(i)))
                         || ((now_ms - stamps[i]) <= window_ms);
   end

   assign all_recent = &recent;

endmodule
`default_nettype wire

/* design/msr_core.sv */
// Tracker state and the single-pass next-state and result logic.
`default_nettype none
module msr_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire msr_pkg::msr_req_type req,
   input  wire msr_pkg::msr_cfg_type cfg,
   output msr_pkg::msr_rsp_type      rsp
);
   import msr_pkg::*;

   logic              level_ff, level_in;
   logic [31:0]       stamps_ff [EDGE_SLOTS];
   logic [31:0]       stamps_in [EDGE_SLOTS];
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [31:0]       hold_dl_ff, hold_dl_in;
   logic [31:0]       start_ff, start_in;
   logic [31:0]       total_ff, total_in;
   logic [7:0]        events_ff, events_in;
   logic              sim_ff, sim_in;
   logic [31:0]       sim_dl_ff, sim_dl_in;
   logic              flag_ff, flag_in;
   logic              taken;
   logic              stamp_wr;
   logic              all_recent;

   msr_burst u_burst (
      .now_ms     (req.now_ms),
      .window_ms  (cfg.burst_window_ms),
      .stamps     (stamps_ff),
      .wr_en      (stamp_wr),
      .wr_slot    (slot_ff),
      .all_recent (all_recent)
   );

   always_comb begin
      level_in  = level_ff;
      stamps_in = stamps_ff;
      slot_in   = slot_ff;
      hold_dl_in = hold_dl_ff;
      start_in  = start_ff;
      total_in  = total_ff;
      events_in = events_ff;
      sim_in    = sim_ff;
      sim_dl_in = sim_dl_ff;
      flag_in   = flag_ff;
      taken     = 1'b0;
      stamp_wr  = 1'b0;
      case (cmd_type'(req.cmd))
         CMD_TICK: begin
            // end an expired pulse, then take the effective level
            sim_in   = sim_ff && (req.now_ms < sim_dl_ff);
            level_in = sim_in || req.raw_level;
            if (level_in && !level_ff) begin
               stamp_wr           = 1'b1;
               stamps_in[slot_ff] = req.now_ms;
               slot_in    = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);
               events_in  = events_ff + 8'd1;
               start_in   = req.now_ms;
               hold_dl_in = req.now_ms + cfg.hold_time_ms;
            end else if (!level_in && level_ff && (start_ff != 32'd0)) begin
               total_in = total_ff + (req.now_ms - start_ff);
               start_in = '0;
            end
            flag_in = all_recent;
         end
         CMD_HOLD: begin
            hold_dl_in = req.now_ms + req.arg_ms;
         end
         CMD_PULSE: begin
            sim_in     = 1'b1;
            sim_dl_in  = req.now_ms + req.arg_ms;
            events_in  = events_ff + 8'd1;
            start_in   = req.now_ms;
            hold_dl_in = req.now_ms + cfg.hold_time_ms;
         end
         CMD_TAKE: begin
            taken   = flag_ff;
            flag_in = 1'b0;
         end
         default: begin
            flag_in = flag_ff;
         end
      endcase

      rsp.motion_level    = level_in;
      rsp.hold_active     = req.now_ms < hold_dl_in;
      rsp.hold_left_ms    = rsp.hold_active ? (hold_dl_in - req.now_ms) : '0;
      rsp.current_high_ms = (level_in && (start_in != 32'd0)) ? (req.now_ms - start_in) : '0;
      rsp.total_high_ms   = total_in;
      rsp.event_count     = events_in;
      rsp.unusual_now     = flag_in;
      rsp.unusual_taken   = taken;
      rsp.simulating      = sim_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= 1'b0;
         for (int i = 0; i < EDGE_SLOTS; i++) begin
            stamps_ff[i] <= '0;
         end
         slot_ff    <= '0;
         hold_dl_ff <= '0;
         start_ff   <= '0;
         total_ff   <= '0;
         events_ff  <= '0;
         sim_ff     <= 1'b0;
         sim_dl_ff  <= '0;
         flag_ff    <= 1'b0;
      end else if (fire) begin
         level_ff   <= level_in;
         stamps_ff  <= stamps_in;
         slot_ff    <= slot_in;
         hold_dl_ff <= hold_dl_in;
         start_ff   <= start_in;
         total_ff   <= total_in;
         events_ff  <= events_in;
         sim_ff     <= sim_in;
         sim_dl_ff  <= sim_dl_in;
         flag_ff    <= flag_in;
      end
   end

endmodule
`default_nettype wire

/* design/motion_sensor_tracker_unit.sv */
// Top level of the motion sensor tracker: request register, tracker core, response register.
// The tracker takes one command item per clock cycle while responses are taken, and
// returns exactly one response item for each: the request lands in an input register,
// the tracker core then updates its state and loads the response register once that
// register is free, and the response waits in its register until taken. Throughput is
// one item per cycle while responses are taken, set by the single state update stage;
// a stalled response holds back new requests only once the input register is also full.
// Register writes take effect in the cycle after the write and are accepted at any time.
`default_nettype none
module motion_sensor_tracker_unit (
   input  wire logic clock,
   input  wire logic reset,
   msr_req_if.sink   req_ch,
   msr_rsp_if.source rsp_ch,
   msr_csr_if.sink   csr_ch
);
   import msr_pkg::*;

   logic        in_valid_ff, in_valid_in;
   msr_req_type in_req_ff, in_req_in;
   logic        out_valid_ff, out_valid_in;
   msr_rsp_type out_rsp_ff, out_rsp_in;
   msr_rsp_type core_rsp;
   msr_cfg_type cfg;
   logic        advance;
   logic        fire;

   msr_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   msr_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (in_req_ff),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = req_ch.ready ? req_ch.valid : in_valid_ff;
      in_req_in    = in_req_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_req_in.cmd       = req_ch.cmd;
         in_req_in.now_ms    = req_ch.now_ms;
         in_req_in.raw_level = req_ch.raw_level;
         in_req_in.arg_ms    = req_ch.arg_ms;
      end
      // hold the response while the sink stalls
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
      out_rsp_in   = fire ? core_rsp : out_rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.motion_level    = out_rsp_ff.motion_level;
   assign rsp_ch.hold_active     = out_rsp_ff.hold_active;
   assign rsp_ch.hold_left_ms    = out_rsp_ff.hold_left_ms;
   assign rsp_ch.current_high_ms = out_rsp_ff.current_high_ms;
   assign rsp_ch.total_high_ms   = out_rsp_ff.total_high_ms;
   assign rsp_ch.event_count     = out_rsp_ff.event_count;
   assign rsp_ch.unusual_now     = out_rsp_ff.unusual_now;
   assign rsp_ch.unusual_taken   = out_rsp_ff.unusual_taken;
   assign rsp_ch.simulating      = out_rsp_ff.simulating;

endmodule
`default_nettype wire

/* design/msr_checker.sv */
// Port checker for the motion sensor tracker, bound to the top level.
`default_nettype none
module msr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        motion_level,
   input wire logic        hold_active,
   input wire logic [31:0] hold_left_ms,
   input wire logic [31:0] current_high_ms,
   input wire logic [31:0] total_high_ms,
   input wire logic [7:0]  event_count,
   input wire logic        unusual_now,
   input wire logic        unusual_taken
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(total_high_ms)
         && $stable(event_count) && $stable(hold_left_ms))
      else $error("response item changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   a_taken_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && unusual_taken |-> !unusual_now)
      else $error("unusual flag still set after it was taken");

   a_hold_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (hold_active == (hold_left_ms != 32'd0)))
      else $error("hold active disagrees with time left");

   a_high_needs_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (current_high_ms != 32'd0) |-> motion_level)
      else $error("motion time reported while level low");

endmodule

bind motion_sensor_tracker_unit msr_checker u_msr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .motion_level    (rsp_ch.motion_level),
   .hold_active     (rsp_ch.hold_active),
   .hold_left_ms    (rsp_ch.hold_left_ms),
   .current_high_ms (rsp_ch.current_high_ms),
   .total_high_ms   (rsp_ch.total_high_ms),
   .event_count     (rsp_ch.event_count),
   .unusual_now     (rsp_ch.unusual_now),
   .unusual_taken   (rsp_ch.unusual_taken)
);
`default_nettype wire
